// File: rtl/tklx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token lexer package
// Shared types, character codes, keyword spellings and helper functions.
// ----------------------------------------------------------------------------
package tklx_pkg;

	localparam int OFFSET_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int TOK_PER_ENTRY   = 3;

	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LBRC  = 8'h7B;
	localparam logic [7:0] CH_RBRC  = 8'h7D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	localparam logic [3:0][7:0] KW_PROC = "proc";
	localparam logic [3:0][7:0] KW_NONE = "none";

	typedef enum logic [3:0] {
		TK_EOF     = 4'd0,
		TK_COMMA   = 4'd1,
		TK_COLON   = 4'd2,
		TK_DASH    = 4'd3,
		TK_ARROW   = 4'd4,
		TK_PLUS    = 4'd5,
		TK_LPAR    = 4'd6,
		TK_RPAR    = 4'd7,
		TK_LBRC    = 4'd8,
		TK_RBRC    = 4'd9,
		TK_LOWERID = 4'd10,
		TK_UPPERID = 4'd11,
		TK_PROC    = 4'd12,
		TK_NONE    = 4'd13,
		TK_INVALID = 4'd14
	} tok_kind_t;

	typedef enum logic [2:0] {
		PM_IDLE  = 3'b001,
		PM_IDENT = 3'b010,
		PM_DASH  = 3'b100
	} pend_mode_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_input;
	} lex_in_t;

	typedef struct packed {
		tok_kind_t   token_kind;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic        last_of_run;
	} lex_out_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [15:0] start;
		logic [15:0] length;
	} tok_t;

	typedef struct packed {
		tok_t [TOK_PER_ENTRY-1:0] tok;
		logic [1:0]               cnt;
	} q_entry_t;

	function automatic logic is_lower(input logic [7:0] c);
		return (c >= CH_LA) && (c <= CH_LZ);
	endfunction

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= CH_UA) && (c <= CH_UZ);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] len);
		return (len == LEN_MAX) ? len : len + 16'd1;
	endfunction

	// Clears a keyword flag once the character at this place differs; clears both past the fourth character.
	function automatic logic [1:0] kw_match(input logic [1:0] flags, input logic [15:0] len,
		input logic [7:0] c);
		logic [1:0] f;
		logic [1:0] pos;
		f   = flags;
		pos = 2'd3 - len[1:0];
		if (len < 16'd4) begin
			if (c != KW_PROC[pos]) f[0] = 1'b0;
			if (c != KW_NONE[pos]) f[1] = 1'b0;
		end else begin
			f = 2'b00;
		end
		return f;
	endfunction

	function automatic tok_kind_t ident_kind(input logic upper, input logic [15:0] len,
		input logic [1:0] flags);
		tok_kind_t k;
		k = upper ? TK_UPPERID : TK_LOWERID;
		if (len == 16'd4) begin
			if (flags[0]) k = TK_PROC;
			else if (flags[1]) k = TK_NONE;
		end
		return k;
	endfunction

endpackage

// File: rtl/tklx_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token lexer front end
// Classifies one byte per cycle while the queue has room and packs the tokens it completes into a
// queue entry.
// ----------------------------------------------------------------------------
module tklx_front #(
	parameter int OFFSET_BITS = tklx_pkg::OFFSET_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tklx_pkg::lex_in_t  in_data,
	input  logic               q_ready,
	output logic               q_push,
	output tklx_pkg::q_entry_t q_entry
);

	tklx_pkg::pend_mode_t   mode_q, mode_b, mode_n;
	logic                   upper_q, upper_b;
	logic [15:0]            len_q, len_b;
	logic [1:0]             flags_q, flags_b;
	logic [OFFSET_BITS-1:0] pstart_q, pstart_b;
	logic [OFFSET_BITS-1:0] offset_q, offset_n;
	logic [7:0]             c;
	logic                   consumed;
	logic                   accept;
	logic [3:0]             cand_v;
	tklx_pkg::tok_t [3:0]   cand;
	tklx_pkg::q_entry_t     entry;
	logic [1:0]             k;

	function automatic logic [15:0] to_start(input logic [OFFSET_BITS-1:0] p);
		logic [OFFSET_BITS+15:0] w;
		w = {16'b0, p};
		return w[15:0];
	endfunction

	assign c        = in_data.char_code;
	assign offset_n = offset_q + 1'b1;
	assign in_ready = q_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		mode_b   = mode_q;
		upper_b  = upper_q;
		len_b    = len_q;
		flags_b  = flags_q;
		pstart_b = pstart_q;
		consumed = 1'b0;
		cand_v   = '0;
		cand     = '0;

		case (mode_q)
			tklx_pkg::PM_DASH: begin
				cand_v[0] = 1'b1;
				if (c == tklx_pkg::CH_GT) begin
					cand[0]  = '{tklx_pkg::TK_ARROW, to_start(pstart_q), 16'd2};
					consumed = 1'b1;
				end else begin
					cand[0] = '{tklx_pkg::TK_DASH, to_start(pstart_q), 16'd1};
				end
				mode_b = tklx_pkg::PM_IDLE;
			end
			tklx_pkg::PM_IDENT: begin
				if (tklx_pkg::is_lower(c) || tklx_pkg::is_upper(c) || tklx_pkg::is_digit(c)) begin
					flags_b  = tklx_pkg::kw_match(flags_q, len_q, c);
					len_b    = tklx_pkg::sat_inc(len_q);
					consumed = 1'b1;
				end else begin
					cand_v[0] = 1'b1;
					cand[0]   = '{tklx_pkg::ident_kind(upper_q, len_q, flags_q),
						to_start(pstart_q), len_q};
					mode_b    = tklx_pkg::PM_IDLE;
				end
			end
			default: begin
				mode_b = tklx_pkg::PM_IDLE;
			end
		endcase

		if (!consumed) begin
			cand_v[1] = 1'b1;
			cand[1]   = '{tklx_pkg::TK_INVALID, to_start(offset_q), 16'd1};
			case (c)
				tklx_pkg::CH_SP, tklx_pkg::CH_TAB, tklx_pkg::CH_CR, tklx_pkg::CH_LF: begin
					cand_v[1] = 1'b0;
				end
				tklx_pkg::CH_NUL:   cand[1].kind = tklx_pkg::TK_EOF;
				tklx_pkg::CH_COMMA: cand[1].kind = tklx_pkg::TK_COMMA;
				tklx_pkg::CH_COLON: cand[1].kind = tklx_pkg::TK_COLON;
				tklx_pkg::CH_PLUS:  cand[1].kind = tklx_pkg::TK_PLUS;
				tklx_pkg::CH_LPAR:  cand[1].kind = tklx_pkg::TK_LPAR;
				tklx_pkg::CH_RPAR:  cand[1].kind = tklx_pkg::TK_RPAR;
				tklx_pkg::CH_LBRC:  cand[1].kind = tklx_pkg::TK_LBRC;
				tklx_pkg::CH_RBRC:  cand[1].kind = tklx_pkg::TK_RBRC;
				tklx_pkg::CH_DASH: begin
					cand_v[1] = 1'b0;
					mode_b    = tklx_pkg::PM_DASH;
					pstart_b  = offset_q;
				end
				default: begin
					if (tklx_pkg::is_lower(c) || tklx_pkg::is_upper(c)) begin
						cand_v[1] = 1'b0;
						mode_b    = tklx_pkg::PM_IDENT;
						pstart_b  = offset_q;
						upper_b   = tklx_pkg::is_upper(c);
						len_b     = 16'd1;
						flags_b   = tklx_pkg::kw_match(2'b11, 16'd0, c);
					end
				end
			endcase
		end

		mode_n = mode_b;
		if (in_data.end_of_input) begin
			case (mode_b)
				tklx_pkg::PM_IDENT: begin
					cand_v[2] = 1'b1;
					cand[2]   = '{tklx_pkg::ident_kind(upper_b, len_b, flags_b),
						to_start(pstart_b), len_b};
				end
				tklx_pkg::PM_DASH: begin
					cand_v[2] = 1'b1;
					cand[2]   = '{tklx_pkg::TK_DASH, to_start(pstart_b), 16'd1};
				end
				default: begin
					cand_v[2] = 1'b0;
				end
			endcase
			mode_n = tklx_pkg::PM_IDLE;
			if (c != tklx_pkg::CH_NUL) begin
				cand_v[3] = 1'b1;
				cand[3]   = '{tklx_pkg::TK_EOF, to_start(offset_n), 16'd0};
			end
		end
	end

	always_comb begin
		entry = '0;
		k     = 2'd0;
		for (int i = 0; i < 4; i++) begin
			if (cand_v[i]) begin
				entry.tok[k] = cand[i];
				k            = k + 2'd1;
			end
		end
		entry.cnt = k;
	end

	assign q_push  = accept && (entry.cnt != 2'd0);
	assign q_entry = entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= tklx_pkg::PM_IDLE;
			upper_q  <= 1'b0;
			len_q    <= 16'd0;
			flags_q  <= 2'b11;
			pstart_q <= '0;
			offset_q <= '0;
		end else if (accept) begin
			mode_q   <= mode_n;
			upper_q  <= upper_b;
			len_q    <= len_b;
			flags_q  <= flags_b;
			pstart_q <= pstart_b;
			offset_q <= offset_n;
		end
	end

endmodule

// File: rtl/tklx_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token lexer entry queue
// Small FIFO of token groups between the front end and the back end.
// ----------------------------------------------------------------------------
module tklx_queue #(
	parameter int QUEUE_DEPTH = tklx_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tklx_pkg::q_entry_t wr_entry,
	output logic               wr_ready,
	input  logic               pop,
	output logic               rd_valid,
	output tklx_pkg::q_entry_t rd_entry
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	tklx_pkg::q_entry_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign wr_ready = (count_q != CNT_FULL);
	assign rd_valid = (count_q != '0);
	assign rd_entry = mem_q[rd_ptr_q];
	assign do_push  = push && wr_ready;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/tklx_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token lexer back end
// Walks the tokens of the queue head and presents them one per transaction.
// ----------------------------------------------------------------------------
module tklx_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_valid,
	input  tklx_pkg::q_entry_t  rd_entry,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output tklx_pkg::lex_out_t  out_data
);

	logic [1:0]     idx_q;
	logic           last;
	logic           accept;
	tklx_pkg::tok_t cur;

	assign cur       = rd_entry.tok[idx_q];
	assign last      = (idx_q == rd_entry.cnt - 2'd1);
	assign out_valid = rd_valid;
	assign accept    = out_valid && out_ready;
	assign pop       = accept && last;

	assign out_data.token_kind   = cur.kind;
	assign out_data.token_start  = cur.start;
	assign out_data.token_length = cur.length;
	assign out_data.last_of_run  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (accept) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// File: rtl/token_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token lexer
// Byte-serial lexical analyzer: a front end classifies source bytes, a queue
// holds the token groups, and a back end hands out tokens one at a time.
// ----------------------------------------------------------------------------
// Channel | Signals                      | Payload
// input   | in_valid, in_ready, in_data  | char_code, end_of_input
// output  | out_valid, out_ready, out_data | token_kind, token_start,
//         |                              | token_length, last_of_run
//
// The front end takes one byte per cycle while the queue has room.
// The back end gives one token per cycle while out_ready is high; a byte that completes
// more than one token has them handed out one at a time, so sustained rate is set by the token count.
// Reset clears the lexer state, the queue and the token index.
// Output stalls back up through the queue; input stalls only when it fills.
// ----------------------------------------------------------------------------
module token_lexer #(
	parameter int OFFSET_BITS = tklx_pkg::OFFSET_BITS_DEF,
	parameter int QUEUE_DEPTH = tklx_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tklx_pkg::lex_in_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output tklx_pkg::lex_out_t out_data
);

	logic               q_push, q_wr_ready, q_pop, q_rd_valid;
	tklx_pkg::q_entry_t q_wr_entry, q_rd_entry;

	tklx_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_ready  (q_wr_ready),
		.q_push   (q_push),
		.q_entry  (q_wr_entry)
	);

	tklx_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr_entry),
		.wr_ready (q_wr_ready),
		.pop      (q_pop),
		.rd_valid (q_rd_valid),
		.rd_entry (q_rd_entry)
	);

	tklx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_valid  (q_rd_valid),
		.rd_entry  (q_rd_entry),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: bench/tb_token_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token lexer testbench
// Feeds source bytes to token_lexer through the valid/ready input channel and
// checks every output token against a cycle-free model of the lexer. Stimulus
// is a directed opening followed by random phrases of identifiers, keywords,
// punctuation, whitespace and stray bytes, with random gaps on the input side
// and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_token_lexer;
	import tklx_pkg::*;

	localparam int TOTAL_ITEMS = 380;
	localparam int SETTLE      = 20;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	lex_in_t  in_data   = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	lex_out_t out_data;

	lex_in_t    source_bytes[$];
	lex_out_t   tokens_due[$];
	int         total_bytes;
	int         accepted_bytes;
	int         feed_gap;
	int         feed_calm;
	int         drain_stall;
	int         drain_calm;
	int         mismatches;
	int         tokens_seen;
	int         keywords_seen;
	int         eofs_seen;

	pend_mode_t  lex_mode;
	logic        lex_upper_first;
	logic [15:0] lex_id_len;
	logic [1:0]  lex_kw_flags;
	logic [15:0] lex_tok_start;
	logic [15:0] lex_offset;

	token_lexer uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #6 clk = ~clk;

	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_alpha(c) || (c >= "0" && c <= "9");
	endfunction

	function automatic logic [7:0] rand_alnum();
		int r;
		r = $urandom_range(0, 61);
		if (r < 26) return 8'(CH_LA + r);
		if (r < 52) return 8'(CH_UA + r - 26);
		return 8'(CH_0 + r - 52);
	endfunction

	task automatic push_token(input tok_kind_t kind, input logic [15:0] start,
		input logic [15:0] len);
		lex_out_t t;
		t.token_kind   = kind;
		t.token_start  = start;
		t.token_length = len;
		t.last_of_run  = 1'b0;
		tokens_due.push_back(t);
	endtask

	task automatic extend_ident(input logic [7:0] c);
		logic [1:0] place;
		place = 2'd3 - lex_id_len[1:0];
		if (lex_id_len < 16'd4) begin
			if (c != KW_PROC[place]) lex_kw_flags[0] = 1'b0;
			if (c != KW_NONE[place]) lex_kw_flags[1] = 1'b0;
		end else begin
			lex_kw_flags = 2'b00;
		end
		if (lex_id_len != LEN_MAX) lex_id_len = lex_id_len + 16'd1;
	endtask

	task automatic close_ident();
		tok_kind_t kind;
		kind = lex_upper_first ? TK_UPPERID : TK_LOWERID;
		if (lex_id_len == 16'd4) begin
			if (lex_kw_flags[0]) kind = TK_PROC;
			else if (lex_kw_flags[1]) kind = TK_NONE;
		end
		push_token(kind, lex_tok_start, lex_id_len);
		lex_mode = PM_IDLE;
	endtask

	task automatic scan_byte(input lex_in_t b);
		logic [7:0]  c;
		logic [15:0] here;
		bit          taken;
		int          base;
		c     = b.char_code;
		here  = lex_offset;
		taken = 1'b0;
		base  = tokens_due.size();
		case (lex_mode)
			PM_DASH: begin
				if (c == CH_GT) begin
					push_token(TK_ARROW, lex_tok_start, 16'd2);
					taken = 1'b1;
				end else begin
					push_token(TK_DASH, lex_tok_start, 16'd1);
				end
				lex_mode = PM_IDLE;
			end
			PM_IDENT: begin
				if (is_alnum(c)) begin
					extend_ident(c);
					taken = 1'b1;
				end else begin
					close_ident();
				end
			end
			default: lex_mode = PM_IDLE;
		endcase
		if (!taken) begin
			case (c)
				CH_SP, CH_TAB, CH_CR, CH_LF: ;
				CH_NUL:   push_token(TK_EOF, here, 16'd1);
				CH_COMMA: push_token(TK_COMMA, here, 16'd1);
				CH_COLON: push_token(TK_COLON, here, 16'd1);
				CH_PLUS:  push_token(TK_PLUS, here, 16'd1);
				CH_LPAR:  push_token(TK_LPAR, here, 16'd1);
				CH_RPAR:  push_token(TK_RPAR, here, 16'd1);
				CH_LBRC:  push_token(TK_LBRC, here, 16'd1);
				CH_RBRC:  push_token(TK_RBRC, here, 16'd1);
				CH_DASH: begin
					lex_mode      = PM_DASH;
					lex_tok_start = here;
				end
				default: begin
					if (is_alpha(c)) begin
						lex_mode        = PM_IDENT;
						lex_tok_start   = here;
						lex_upper_first = (c <= CH_UZ);
						lex_id_len      = 16'd0;
						lex_kw_flags    = 2'b11;
						extend_ident(c);
					end else begin
						push_token(TK_INVALID, here, 16'd1);
					end
				end
			endcase
		end
		lex_offset = here + 16'd1;
		if (b.end_of_input) begin
			if (lex_mode == PM_IDENT) close_ident();
			else if (lex_mode == PM_DASH) push_token(TK_DASH, lex_tok_start, 16'd1);
			lex_mode = PM_IDLE;
			if (c != CH_NUL) push_token(TK_EOF, lex_offset, 16'd0);
		end
		if (tokens_due.size() > base) tokens_due[tokens_due.size() - 1].last_of_run = 1'b1;
	endtask

	task automatic add_byte(input logic [7:0] c, input logic eoi);
		lex_in_t b;
		b.char_code    = c;
		b.end_of_input = eoi;
		source_bytes.push_back(b);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
	endtask

	task automatic add_phrase();
		string      near_kw[9] = '{"proc", "none", "pro", "procs", "nonex", "Proc", "NONE",
			"nOne", "pr0c"};
		logic [7:0] punct[7] = '{CH_COMMA, CH_COLON, CH_PLUS, CH_LPAR, CH_RPAR, CH_LBRC,
			CH_RBRC};
		logic [7:0] blank[4] = '{CH_SP, CH_TAB, CH_CR, CH_LF};
		logic [7:0] odd[5] = '{"!", "#", ".", ">", "0"};
		int         r;
		int         len;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			if ($urandom_range(0, 4) == 0) begin
				add_text(near_kw[$urandom_range(0, 8)]);
			end else begin
				len = $urandom_range(1, 9);
				add_byte($urandom_range(0, 1) ? 8'($urandom_range(CH_LA, CH_LZ)) :
					8'($urandom_range(CH_UA, CH_UZ)), 1'b0);
				for (int i = 1; i < len; i++) add_byte(rand_alnum(), 1'b0);
			end
		end else if (r < 55) begin
			add_byte(punct[$urandom_range(0, 6)], 1'b0);
		end else if (r < 62) begin
			add_byte(CH_DASH, 1'b0);
		end else if (r < 68) begin
			add_text("->");
		end else if (r < 80) begin
			add_byte(blank[$urandom_range(0, 3)], 1'b0);
		end else if (r < 84) begin
			add_byte(CH_NUL, 1'b0);
		end else if (r < 90) begin
			add_byte($urandom_range(0, 1) ? 8'($urandom_range(128, 255)) :
				odd[$urandom_range(0, 4)], 1'b0);
		end else begin
			add_byte(8'($urandom_range(0, 255)), 1'b0);
		end
		if ($urandom_range(0, 99) < 4) source_bytes[source_bytes.size() - 1].end_of_input = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			feed_gap <= 0;
		end else if (!(in_valid && !in_ready)) begin
			if (in_valid) begin
				void'(source_bytes.pop_front());
				accepted_bytes++;
			end
			if (feed_gap > 0) begin
				feed_gap <= feed_gap - 1;
				in_valid <= 1'b0;
			end else if (source_bytes.size() > 0) begin
				in_valid <= 1'b1;
				in_data  <= source_bytes[0];
				feed_gap <= pick_gap(feed_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		int g;
		if (!arst_n) begin
			out_ready   <= 1'b0;
			drain_stall <= 0;
		end else if (drain_stall > 0) begin
			drain_stall <= drain_stall - 1;
			out_ready   <= 1'b0;
		end else begin
			g = pick_gap(drain_calm);
			if (g == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready   <= 1'b0;
				drain_stall <= g - 1;
			end
		end
	end

	always @(posedge clk) begin
		lex_out_t want;
		if (arst_n) begin
			if (in_valid && in_ready) scan_byte(in_data);
			if (out_valid && out_ready) begin
				tokens_seen++;
				if (out_data.token_kind == TK_PROC || out_data.token_kind == TK_NONE)
					keywords_seen++;
				if (out_data.token_kind == TK_EOF) eofs_seen++;
				if (tokens_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected token: kind %0d start %0d length %0d last %0b",
							out_data.token_kind, out_data.token_start,
							out_data.token_length, out_data.last_of_run);
				end else begin
					want = tokens_due.pop_front();
					if (out_data.token_kind !== want.token_kind ||
						out_data.token_start !== want.token_start ||
						out_data.token_length !== want.token_length ||
						out_data.last_of_run !== want.last_of_run) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Token %0d mismatch:", tokens_seen);
							$display("  expected kind %0d start %0d length %0d last %0b",
								want.token_kind, want.token_start,
								want.token_length, want.last_of_run);
							$display("  actual   kind %0d start %0d length %0d last %0b",
								out_data.token_kind, out_data.token_start,
								out_data.token_length, out_data.last_of_run);
						end
					end
				end
			end
		end
	end

	initial begin
		lex_mode        = PM_IDLE;
		lex_upper_first = 1'b0;
		lex_id_len      = 16'd0;
		lex_kw_flags    = 2'b11;
		lex_tok_start   = 16'd0;
		lex_offset      = 16'd0;
		accepted_bytes  = 0;
		feed_calm       = 0;
		drain_calm      = 0;
		mismatches      = 0;
		tokens_seen     = 0;
		keywords_seen   = 0;
		eofs_seen       = 0;

		add_text("proc,none Z9->-(:+){}\n");
		add_byte(8'hFF, 1'b0);
		add_byte(CH_NUL, 1'b0);
		add_byte("a", 1'b1);
		add_byte(CH_DASH, 1'b1);
		add_byte(CH_NUL, 1'b1);
		while (source_bytes.size() < TOTAL_ITEMS) add_phrase();
		add_byte("x", 1'b1);
		total_bytes = source_bytes.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_bytes < total_bytes) @(negedge clk);
		while (tokens_due.size() > 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);

		if (tokens_due.size() > 0) begin
			mismatches++;
			$display("%0d expected tokens never arrived", tokens_due.size());
		end
		$display("Lexed %0d source bytes into %0d tokens under input gaps and output stalls.",
			total_bytes, tokens_seen);
		$display("Seen: %0d keywords, %0d EOF tokens; %0d mismatches.",
			keywords_seen, eofs_seen, mismatches);
		if (mismatches == 0) begin
			$display("token_lexer verification clean");
		end else begin
			$display("token_lexer verification failed");
		end
		$finish;
	end

	initial begin
		#(64'd4_000_000);
		$display("Timeout with %0d of %0d bytes accepted and %0d tokens pending.",
			accepted_bytes, total_bytes, tokens_due.size());
		$display("token_lexer verification failed");
		$finish;
	end

endmodule
